// ----- src/bsp_pkg.sv -----
package bsp_pkg;

    // Fixed field widths
    localparam int ADDR_W   = 48;
    localparam int COUNT_W  = 32;
    localparam int SECTOR_W = 39;
    localparam int FIRST_W  = 9;
    localparam int CHUNK_W  = 18;
    localparam int POS_W    = 17;

    // Internal widths sized for the largest sector and transfer sizes
    localparam int LEN_W    = 21;
    localparam int OFS_W    = 12;

    // Command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;
    localparam logic [1:0] CMD_RMW   = 2'd3;

    // Status codes
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    // Mode codes
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [ADDR_W-1:0]  byte_offset;
        logic [COUNT_W-1:0] byte_count;
    } t_req;

    typedef struct packed {
        logic                status;
        logic [1:0]          command;
        logic [SECTOR_W-1:0] start_sector;
        logic [FIRST_W-1:0]  first_byte;
        logic [CHUNK_W-1:0]  chunk_bytes;
        logic [POS_W-1:0]    data_position;
        logic [CHUNK_W-1:0]  granted_bytes;
        logic                last;
    } t_cmd;

    // One classified request as it waits between front and back
    typedef struct packed {
        logic                wr;
        logic                rej;
        logic [LEN_W-1:0]    len;
        logic [OFS_W-1:0]    so;
        logic                has_head;
        logic                has_mid;
        logic                has_tail;
        logic [LEN_W-1:0]    hchunk;
        logic [LEN_W-1:0]    mchunk;
        logic [LEN_W-1:0]    tchunk;
        logic [SECTOR_W-1:0] sec_head;
        logic [SECTOR_W-1:0] sec_mid;
        logic [SECTOR_W-1:0] sec_tail;
    } t_split;

endpackage

// ----- src/byte_range_sector_splitter.sv -----
// Channel   | Valid         | Stall         | Payload
// ----------+---------------+---------------+--------------------------
// request   | i_req_valid   | o_req_stall   | i_req   (bsp_pkg::t_req)
// command   | o_cmd_valid   | i_cmd_stall   | o_cmd   (bsp_pkg::t_cmd)
// config    | i_cfg_we      | -             | i_cfg_wdata (capacity)
//
// Each request yields one to three commands, one per cycle while i_cmd_stall
// is low; the first command passes through the clamp register, the split
// queue and the output register.
// A two-entry queue between the front and the command sequencer lets a new
// request be clamped and split while the previous one is still emitting.
// Synchronous active-low reset clears all valids; capacity resets to 0.
module byte_range_sector_splitter #(
    parameter int SECTOR_BYTES = 512,
    parameter int MAX_TRANSFER = 131072
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [47:0]     i_cfg_wdata,
    input  logic            i_req_valid,
    output logic            o_req_stall,
    input  bsp_pkg::t_req   i_req,
    output logic            o_cmd_valid,
    input  logic            i_cmd_stall,
    output bsp_pkg::t_cmd   o_cmd
);
    import bsp_pkg::*;

    logic [47:0] r_capacity;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    t_split      q_wdata;
    t_split      q_rdata;

    // Load disk capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    bsp_front #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_capacity  (r_capacity),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_q_push    (q_push),
        .i_q_full    (q_full),
        .o_q_data    (q_wdata)
    );

    bsp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    bsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_cmd_valid (o_cmd_valid),
        .i_cmd_stall (i_cmd_stall),
        .o_cmd       (o_cmd)
    );

endmodule

// ----- src/bsp_front.sv -----
module bsp_front #(
    parameter int SECTOR_BYTES = 512,
    parameter int MAX_TRANSFER = 131072
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [47:0]            i_capacity,
    input  logic                   i_req_valid,
    output logic                   o_req_stall,
    input  bsp_pkg::t_req          i_req,
    output logic                   o_q_push,
    input  logic                   i_q_full,
    output bsp_pkg::t_split        o_q_data
);
    import bsp_pkg::*;

    localparam int SB = $clog2(SECTOR_BYTES);

    logic [ADDR_W:0]    diff;
    logic               neg;
    logic [ADDR_W-1:0]  avail;
    logic [ADDR_W-1:0]  cnt;
    logic [ADDR_W-1:0]  len_c;
    logic               rej;
    logic [LEN_W-1:0]   len_m;

    logic               r_a_valid;
    logic               r_a_wr;
    logic               r_a_rej;
    logic [LEN_W-1:0]   r_a_len;
    logic [ADDR_W-1:0]  r_a_off;
    logic               accept;

    logic [SB-1:0]      so;
    logic [SECTOR_W-1:0] sec0;
    logic [LEN_W-1:0]   room;
    logic [LEN_W-1:0]   hchunk;
    logic [LEN_W-1:0]   rem;
    logic [LEN_W-1:0]   mchunk;
    logic [LEN_W-1:0]   tchunk;
    logic               has_head;
    logic               has_mid;
    logic [SECTOR_W-1:0] sec_mid;

    // Clamp the request against the capacity and the transfer limit
    always_comb begin
        diff  = {1'b0, i_capacity} - {1'b0, i_req.byte_offset};
        neg   = diff[ADDR_W];
        avail = diff[ADDR_W-1:0];
        cnt   = ADDR_W'(i_req.byte_count);
        rej   = 1'b0;
        len_c = cnt;
        if (i_req.mode == MODE_WRITE) begin
            rej = neg || (cnt > avail);
        end else if (neg || avail == '0) begin
            len_c = '0;
        end else if (cnt > avail) begin
            len_c = avail;
        end
        if (rej) begin
            len_m = '0;
        end else if (len_c > ADDR_W'(MAX_TRANSFER)) begin
            len_m = LEN_W'(MAX_TRANSFER);
        end else begin
            len_m = LEN_W'(len_c);
        end
    end

    assign o_q_push    = r_a_valid && !i_q_full;
    assign o_req_stall = r_a_valid && !o_q_push;
    assign accept      = i_req_valid && !o_req_stall;

    // Hold the clamped request for the split stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (o_q_push) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_wr  <= i_req.mode;
            r_a_rej <= rej;
            r_a_len <= len_m;
            r_a_off <= i_req.byte_offset;
        end
    end

    // Split into head, aligned middle and tail pieces
    always_comb begin
        so       = r_a_off[SB-1:0];
        sec0     = SECTOR_W'(r_a_off >> SB);
        has_head = (so != '0) && (r_a_len != '0);
        room     = LEN_W'(SECTOR_BYTES) - LEN_W'(so);
        if (!has_head) begin
            hchunk = '0;
        end else if (room > r_a_len) begin
            hchunk = r_a_len;
        end else begin
            hchunk = room;
        end
        rem     = r_a_len - hchunk;
        has_mid = rem >= LEN_W'(SECTOR_BYTES);
        mchunk  = has_mid ? (rem & ~LEN_W'(SECTOR_BYTES - 1)) : '0;
        tchunk  = rem - mchunk;
        sec_mid = sec0 + SECTOR_W'(has_head);

        o_q_data.wr       = r_a_wr;
        o_q_data.rej      = r_a_rej;
        o_q_data.len      = r_a_len;
        o_q_data.so       = OFS_W'(so);
        o_q_data.has_head = has_head;
        o_q_data.has_mid  = has_mid;
        o_q_data.has_tail = tchunk != '0;
        o_q_data.hchunk   = hchunk;
        o_q_data.mchunk   = mchunk;
        o_q_data.tchunk   = tchunk;
        o_q_data.sec_head = sec0;
        o_q_data.sec_mid  = sec_mid;
        o_q_data.sec_tail = sec_mid + SECTOR_W'(mchunk >> SB);
    end

endmodule

// ----- src/bsp_fifo.sv -----
module bsp_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bsp_pkg::t_split i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output bsp_pkg::t_split o_data
);
    import bsp_pkg::*;

    t_split     r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- src/bsp_back.sv -----
module bsp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  bsp_pkg::t_split i_q_data,
    output logic            o_q_pop,
    output logic            o_cmd_valid,
    input  logic            i_cmd_stall,
    output bsp_pkg::t_cmd   o_cmd
);
    import bsp_pkg::*;

    logic       r_valid;
    t_cmd       r_cmd;
    logic [2:0] r_done;
    logic [2:0] n_done;
    t_cmd       n_cmd;
    logic       adv;
    logic       fire;
    logic       p_head;
    logic       p_mid;
    logic       p_tail;
    logic [LEN_W-1:0] pos_tail;

    assign adv  = !r_valid || !i_cmd_stall;
    assign fire = i_q_valid && adv;

    // Pick the next pending piece of the request at the queue head
    always_comb begin
        p_head   = i_q_data.has_head && !r_done[0];
        p_mid    = i_q_data.has_mid  && !r_done[1];
        p_tail   = i_q_data.has_tail && !r_done[2];
        pos_tail = i_q_data.hchunk + i_q_data.mchunk;
        n_done   = r_done;

        n_cmd.status        = i_q_data.rej ? ST_REJECT : ST_OK;
        n_cmd.command       = CMD_NONE;
        n_cmd.start_sector  = '0;
        n_cmd.first_byte    = '0;
        n_cmd.chunk_bytes   = '0;
        n_cmd.data_position = '0;
        n_cmd.granted_bytes = CHUNK_W'(i_q_data.len);
        n_cmd.last          = 1'b1;

        if (p_head) begin
            n_cmd.command      = i_q_data.wr ? CMD_RMW : CMD_READ;
            n_cmd.start_sector = i_q_data.sec_head;
            n_cmd.first_byte   = FIRST_W'(i_q_data.so);
            n_cmd.chunk_bytes  = CHUNK_W'(i_q_data.hchunk);
            n_cmd.last         = !(p_mid || p_tail);
            n_done[0]          = 1'b1;
        end else if (p_mid) begin
            n_cmd.command       = i_q_data.wr ? CMD_WRITE : CMD_READ;
            n_cmd.start_sector  = i_q_data.sec_mid;
            n_cmd.chunk_bytes   = CHUNK_W'(i_q_data.mchunk);
            n_cmd.data_position = POS_W'(i_q_data.hchunk);
            n_cmd.last          = !p_tail;
            n_done[1]           = 1'b1;
        end else if (p_tail) begin
            n_cmd.command       = i_q_data.wr ? CMD_RMW : CMD_READ;
            n_cmd.start_sector  = i_q_data.sec_tail;
            n_cmd.chunk_bytes   = CHUNK_W'(i_q_data.tchunk);
            n_cmd.data_position = POS_W'(pos_tail);
            n_done[2]           = 1'b1;
        end
    end

    // Drop the request from the queue with its final command
    assign o_q_pop = fire && n_cmd.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_done  <= 3'b000;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                r_done  <= n_cmd.last ? 3'b000 : n_done;
            end else if (adv) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the command until taken
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule
